// ----- rtl/salct_pkg.sv -----
// Shared types, constants and register codes of the cache tag controller.
package salct_pkg;

    localparam int MAX_SETS = 64;
    localparam int MAX_WAYS = 8;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_LOG2_MAX = $clog2(MAX_SETS);

    // Configuration register widths and limits
    localparam int BLK_LOG2_W = 4;
    localparam int SET_LOG2_W = 3;
    localparam int WAYS_W     = 4;
    localparam int BLK_LOG2_MIN = 2;
    localparam int BLK_LOG2_MAX = 12;

    localparam logic [BLK_LOG2_W-1:0] BLK_LOG2_RESET = 4'd3;
    localparam logic [SET_LOG2_W-1:0] SET_LOG2_RESET = 3'd3;
    localparam logic [WAYS_W-1:0]     WAYS_RESET     = 4'd4;

    // APB register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SET_COUNT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WAYS       = 2'd2;

    // Result field widths
    localparam int WAY_OUT_W = 3;
    localparam int SET_OUT_W = 6;

    // Statistic counters, in the order they appear in the result
    localparam int NUM_STATS = 7;
    localparam int STAT_READS        = 0;
    localparam int STAT_WRITES       = 1;
    localparam int STAT_READ_HITS    = 2;
    localparam int STAT_WRITE_HITS   = 3;
    localparam int STAT_READ_MISSES  = 4;
    localparam int STAT_WRITE_MISSES = 5;
    localparam int STAT_WRITEBACKS   = 6;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [BLK_LOG2_W-1:0] block_log2;
        logic [SET_LOG2_W-1:0] set_log2;
        logic [WAYS_W-1:0]     ways;
    } cfg_t;

    typedef struct packed {
        logic                is_write;
        logic [ADDR_W-1:0]   addr;
        logic [SET_W-1:0]    set;
        logic [ADDR_W-1:0]   tag_mask;
        logic [MAX_WAYS-1:0] in_use;
    } item_t;

    typedef struct packed {
        logic        valid;
        item_t       item;
    } queue_head_t;

    typedef struct packed {
        logic              valid;
        logic              dirty;
        logic [ADDR_W-1:0] block_addr;
        logic [CNT_W-1:0]  stamp;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic [NUM_STATS-1:0][CNT_W-1:0] stats;
        logic [CNT_W-1:0]                access_total;
        logic [SET_OUT_W-1:0]            set;
        logic [WAY_OUT_W-1:0]            way;
        logic                            wrote_back;
        logic                            hit;
    } result_t;

    localparam int OUT_FIELDS_W = $bits(result_t);
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// ----- rtl/salct_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module salct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/salct_front.sv -----
// Front part: accepts accesses, decodes the geometry and queues them for the back part.
module salct_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_kind,
    input  logic [salct_pkg::ADDR_W-1:0] s_addr,
    input  salct_pkg::cfg_t             cfg,
    output salct_pkg::queue_head_t      q_head,
    input  logic                        q_pop
);

    localparam int QPTR_W = (salct_pkg::QDEPTH > 1) ? $clog2(salct_pkg::QDEPTH) : 1;
    localparam int QCNT_W = $clog2(salct_pkg::QDEPTH + 1);

    salct_pkg::item_t            fifo_reg [salct_pkg::QDEPTH];
    logic [QPTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]           count_reg, count_next;

    logic [salct_pkg::BLK_LOG2_W-1:0] blk_log2;
    logic [salct_pkg::SET_LOG2_W-1:0] set_log2;
    logic [salct_pkg::WAYS_W-1:0]     ways;
    logic [4:0]                       tag_shift;
    logic [salct_pkg::ADDR_W-1:0]     set_field;
    salct_pkg::item_t                 item;
    logic                             push;

    // Clamp the configured geometry into the supported ranges
    always_comb begin
        if (int'(cfg.block_log2) < salct_pkg::BLK_LOG2_MIN) begin
            blk_log2 = salct_pkg::BLK_LOG2_W'(salct_pkg::BLK_LOG2_MIN);
        end else if (int'(cfg.block_log2) > salct_pkg::BLK_LOG2_MAX) begin
            blk_log2 = salct_pkg::BLK_LOG2_W'(salct_pkg::BLK_LOG2_MAX);
        end else begin
            blk_log2 = cfg.block_log2;
        end

        if (int'(cfg.set_log2) > salct_pkg::SET_LOG2_MAX) begin
            set_log2 = salct_pkg::SET_LOG2_W'(salct_pkg::SET_LOG2_MAX);
        end else begin
            set_log2 = cfg.set_log2;
        end

        if (cfg.ways == '0) begin
            ways = salct_pkg::WAYS_W'(1);
        end else if (int'(cfg.ways) > salct_pkg::MAX_WAYS) begin
            ways = salct_pkg::WAYS_W'(salct_pkg::MAX_WAYS);
        end else begin
            ways = cfg.ways;
        end
    end

    always_comb begin
        tag_shift     = 5'(blk_log2) + 5'(set_log2);
        item.is_write = s_kind;
        item.addr     = s_addr & ({salct_pkg::ADDR_W{1'b1}} << blk_log2);
        set_field     = (s_addr >> blk_log2) & ~({salct_pkg::ADDR_W{1'b1}} << set_log2);
        item.set      = salct_pkg::SET_W'(set_field);
        item.tag_mask = {salct_pkg::ADDR_W{1'b1}} << tag_shift;
        for (int w = 0; w < salct_pkg::MAX_WAYS; w++) begin
            item.in_use[w] = (w < int'(ways));
        end
    end

    assign s_tready = (int'(count_reg) != salct_pkg::QDEPTH);
    assign push     = s_tvalid && s_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == salct_pkg::QDEPTH - 1) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (q_pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == salct_pkg::QDEPTH - 1) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !q_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && q_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = fifo_reg[rd_ptr_reg];

endmodule

// ----- rtl/salct_back.sv -----
// Back part: set lookup, LRU victim choice, line update and statistics.
module salct_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  salct_pkg::queue_head_t q_head,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output salct_pkg::result_t     result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic                           en;
        logic [salct_pkg::CNT_W-1:0]    stamp;
        logic [salct_pkg::WAY_W-1:0]    idx;
    } node_t;

    localparam int LVLS = salct_pkg::WAY_W;

    state_t                         state_reg;
    salct_pkg::item_t               item_reg;
    logic                           row_live_reg;
    logic [salct_pkg::MAX_SETS-1:0] row_valid_reg;
    logic                           hit_reg;
    logic                           wb_reg;
    logic [salct_pkg::WAY_W-1:0]    way_reg;
    salct_pkg::row_t                new_row_reg;
    logic [salct_pkg::CNT_W-1:0]    access_reg;
    logic [salct_pkg::CNT_W-1:0]    stat_reg [salct_pkg::NUM_STATS];
    logic                           m_valid_reg;
    logic                           res_hit_reg;
    logic                           res_wb_reg;
    logic [salct_pkg::WAY_OUT_W-1:0] res_way_reg;
    logic [salct_pkg::SET_OUT_W-1:0] res_set_reg;

    logic [salct_pkg::ROW_W-1:0]    ram_rdata;
    logic [salct_pkg::ROW_W-1:0]    ram_wdata;
    logic                           ram_we;
    salct_pkg::row_t                row_eff;
    salct_pkg::row_t                new_row;
    salct_pkg::row_t                wr_row;
    logic [salct_pkg::MAX_WAYS-1:0] hit_vec;
    logic [salct_pkg::MAX_WAYS-1:0] inv_vec;
    logic [salct_pkg::WAY_W-1:0]    hit_way;
    logic [salct_pkg::WAY_W-1:0]    inv_way;
    logic [salct_pkg::WAY_W-1:0]    victim;
    logic                           hit_any;
    logic                           inv_any;
    logic                           wb;
    logic                           slot_free;
    logic [salct_pkg::CNT_W-1:0]    access_next;
    node_t                          tree [LVLS+1][salct_pkg::MAX_WAYS];

    function automatic node_t pick_older(input node_t a, input node_t b);
        node_t r;
        if (!a.en) begin
            r = b;
        end else if (!b.en) begin
            r = a;
        end else if (b.stamp < a.stamp) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

    salct_ram #(
        .WIDTH (salct_pkg::ROW_W),
        .DEPTH (salct_pkg::MAX_SETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (item_reg.set),
        .wdata (ram_wdata),
        .raddr (q_head.item.set),
        .rdata (ram_rdata)
    );

    assign q_pop     = (state_reg == ST_IDLE) && q_head.valid;
    assign slot_free = !m_valid_reg || m_ready;
    assign ram_we    = (state_reg == ST_UPDATE) && slot_free;

    // A set that was never written reads as empty
    always_comb begin
        row_eff = row_live_reg ? salct_pkg::row_t'(ram_rdata) : '0;
        for (int w = 0; w < salct_pkg::MAX_WAYS; w++) begin
            hit_vec[w] = item_reg.in_use[w] && row_eff[w].valid
                         && ((row_eff[w].block_addr & item_reg.tag_mask)
                             == (item_reg.addr & item_reg.tag_mask));
            inv_vec[w] = item_reg.in_use[w] && !row_eff[w].valid;
        end
        hit_any = |hit_vec;
        inv_any = |inv_vec;
        hit_way = '0;
        inv_way = '0;
        for (int w = salct_pkg::MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = salct_pkg::WAY_W'(w);
            end
            if (inv_vec[w]) begin
                inv_way = salct_pkg::WAY_W'(w);
            end
        end
    end

    // Oldest stamp among the ways in use; ties keep the lower way
    always_comb begin
        for (int l = 0; l <= LVLS; l++) begin
            for (int n = 0; n < salct_pkg::MAX_WAYS; n++) begin
                tree[l][n] = '0;
            end
        end
        for (int n = 0; n < salct_pkg::MAX_WAYS; n++) begin
            tree[0][n].en    = item_reg.in_use[n];
            tree[0][n].stamp = row_eff[n].stamp;
            tree[0][n].idx   = salct_pkg::WAY_W'(n);
        end
        for (int l = 0; l < LVLS; l++) begin
            for (int n = 0; n < (salct_pkg::MAX_WAYS >> (l + 1)); n++) begin
                tree[l+1][n] = pick_older(tree[l][2*n], tree[l][2*n+1]);
            end
        end
    end

    always_comb begin
        if (hit_any) begin
            victim = hit_way;
        end else if (inv_any) begin
            victim = inv_way;
        end else begin
            victim = tree[LVLS][0].idx;
        end
        wb = !hit_any && !inv_any && row_eff[victim].dirty;

        new_row = row_eff;
        if (!hit_any) begin
            new_row[victim].valid      = 1'b1;
            new_row[victim].dirty      = 1'b0;
            new_row[victim].block_addr = item_reg.addr;
        end
        if (item_reg.is_write) begin
            new_row[victim].dirty = 1'b1;
        end
    end

    assign access_next = access_reg + salct_pkg::CNT_W'(1);

    always_comb begin
        wr_row                = new_row_reg;
        wr_row[way_reg].stamp = access_next;
        ram_wdata             = salct_pkg::ROW_W'(wr_row);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            access_reg    <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < salct_pkg::NUM_STATS; i++) begin
                stat_reg[i] <= '0;
            end
        end else begin
            // In the update state the slot is refilled whenever it is freed
            if (m_valid_reg && m_ready && (state_reg != ST_UPDATE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_head.valid) begin
                        item_reg     <= q_head.item;
                        row_live_reg <= row_valid_reg[q_head.item.set];
                        state_reg    <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    hit_reg     <= hit_any;
                    wb_reg      <= wb;
                    way_reg     <= victim;
                    new_row_reg <= new_row;
                    state_reg   <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (slot_free) begin
                        row_valid_reg[item_reg.set] <= 1'b1;
                        access_reg <= access_next;
                        if (item_reg.is_write) begin
                            stat_reg[salct_pkg::STAT_WRITES] <=
                                stat_reg[salct_pkg::STAT_WRITES] + salct_pkg::CNT_W'(1);
                            if (hit_reg) begin
                                stat_reg[salct_pkg::STAT_WRITE_HITS] <=
                                    stat_reg[salct_pkg::STAT_WRITE_HITS]
                                    + salct_pkg::CNT_W'(1);
                            end else begin
                                stat_reg[salct_pkg::STAT_WRITE_MISSES] <=
                                    stat_reg[salct_pkg::STAT_WRITE_MISSES]
                                    + salct_pkg::CNT_W'(1);
                            end
                        end else begin
                            stat_reg[salct_pkg::STAT_READS] <=
                                stat_reg[salct_pkg::STAT_READS] + salct_pkg::CNT_W'(1);
                            if (hit_reg) begin
                                stat_reg[salct_pkg::STAT_READ_HITS] <=
                                    stat_reg[salct_pkg::STAT_READ_HITS]
                                    + salct_pkg::CNT_W'(1);
                            end else begin
                                stat_reg[salct_pkg::STAT_READ_MISSES] <=
                                    stat_reg[salct_pkg::STAT_READ_MISSES]
                                    + salct_pkg::CNT_W'(1);
                            end
                        end
                        if (wb_reg) begin
                            stat_reg[salct_pkg::STAT_WRITEBACKS] <=
                                stat_reg[salct_pkg::STAT_WRITEBACKS] + salct_pkg::CNT_W'(1);
                        end
                        res_hit_reg <= hit_reg;
                        res_wb_reg  <= wb_reg;
                        res_way_reg <= salct_pkg::WAY_OUT_W'(way_reg);
                        res_set_reg <= salct_pkg::SET_OUT_W'(item_reg.set);
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The counters only move when the result slot is free, so they can
    // feed the result directly.
    always_comb begin
        result.hit          = res_hit_reg;
        result.wrote_back   = res_wb_reg;
        result.way          = res_way_reg;
        result.set          = res_set_reg;
        result.access_total = access_reg;
        for (int i = 0; i < salct_pkg::NUM_STATS; i++) begin
            result.stats[i] = stat_reg[i];
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/set_assoc_lru_cache_tags_core.sv -----
// Top level of the set-associative LRU cache tag and replacement controller.
//
// Each transfer on the slave stream is one read or write access; for each the
// block returns one result transfer on the master stream with the hit flag, a
// write-back flag for a dirty victim, the way and set used, and the running
// statistics after this access. Up to 8 ways of up to 64 sets are tracked;
// each set is held as one row of a RAM (tags, valid and dirty bits, and LRU
// stamps of all its ways), and a flip-flop per set marks whether the set has
// been written since reset, so the store reads as empty after reset with no
// clearing pass. The front part decodes the geometry and places accesses in a
// two-entry queue; the back part does a read-modify-write of the set row. Each
// access passes the back part in order (row read, tag compare and LRU victim
// choice, row write-back), and the back part takes no new access until the
// row write-back, which waits for a free result slot, is done. The result
// stays in an output register while the queue keeps taking new accesses. The
// geometry registers sit on the APB port: block_size_log2 at 0x0,
// set_count_log2 at 0x4 and ways_in_use at 0x8; pready is always high and a
// write takes effect in its access cycle. They are to be written only while
// no access is outstanding.
module set_assoc_lru_cache_tags_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Slave stream: tdata = address[31:0]; tuser = kind (0 read, 1 write)
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [salct_pkg::ADDR_W-1:0]       s_tdata,
    input  logic                               s_tuser,
    // Master stream: tdata = hit[0], wrote_back[1], way_used[4:2],
    // set_index[10:5], access_total[42:11], read_total[74:43],
    // write_total[106:75], read_hits[138:107], write_hits[170:139],
    // read_misses[202:171], write_misses[234:203],
    // writeback_total[266:235], zero padding[271:267]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [salct_pkg::OUT_DATA_W-1:0]   m_tdata,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [salct_pkg::PADDR_W-1:0]      paddr,
    input  logic [salct_pkg::PDATA_W-1:0]      pwdata,
    output logic [salct_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);

    salct_pkg::cfg_t        cfg_reg;
    salct_pkg::queue_head_t q_head;
    salct_pkg::result_t     result;
    logic                   q_pop;
    logic                   cfg_write;
    logic [salct_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[salct_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Geometry registers; each keeps only its own width of the written data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_log2 <= salct_pkg::BLK_LOG2_RESET;
            cfg_reg.set_log2   <= salct_pkg::SET_LOG2_RESET;
            cfg_reg.ways       <= salct_pkg::WAYS_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                salct_pkg::REG_BLOCK_SIZE: begin
                    cfg_reg.block_log2 <= pwdata[salct_pkg::BLK_LOG2_W-1:0];
                end
                salct_pkg::REG_SET_COUNT: begin
                    cfg_reg.set_log2 <= pwdata[salct_pkg::SET_LOG2_W-1:0];
                end
                salct_pkg::REG_WAYS: begin
                    cfg_reg.ways <= pwdata[salct_pkg::WAYS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            salct_pkg::REG_BLOCK_SIZE: prdata = salct_pkg::PDATA_W'(cfg_reg.block_log2);
            salct_pkg::REG_SET_COUNT:  prdata = salct_pkg::PDATA_W'(cfg_reg.set_log2);
            salct_pkg::REG_WAYS:       prdata = salct_pkg::PDATA_W'(cfg_reg.ways);
            default:                   prdata = '0;
        endcase
    end

    salct_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_addr   (s_tdata),
        .cfg      (cfg_reg),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    salct_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .result  (result)
    );

    // The packed result struct already matches the tdata layout, its last field at
    // the lowest bit; the size cast fills the top byte with zeros.
    assign m_tdata = salct_pkg::OUT_DATA_W'(result);

endmodule
